// File: rtl/light_level_derating_defines.svh
// assertion macros shared by the light level derating rtl
`ifndef LIGHT_LEVEL_DERATING_DEFINES_SVH
`define LIGHT_LEVEL_DERATING_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define LLD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define LLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lld_pkg.sv
// types and constants for the light level derating block
`default_nettype none

package lld_pkg;

    typedef enum logic
    {
        ACT_START = 1'b0,
        ACT_TICK  = 1'b1
    } action_t;

    typedef enum logic [7:0]
    {
        REG_MAX_TEMPERATURE   = 8'd0,
        REG_LOW_BATTERY_LEVEL = 8'd1
    } cfg_reg_t;

    localparam logic [7:0] MAX_TEMPERATURE_RST   = 8'd195;
    localparam logic [7:0] LOW_BATTERY_LEVEL_RST = 8'd130;

    localparam logic [7:0] HEAT_DEBOUNCE = 8'd15;
    localparam logic [3:0] LOW_READINGS  = 4'd8;
    localparam logic [7:0] STEP_UP_GAP   = 8'd2;

    typedef struct packed
    {
        logic [7:0] battery_raw;
        logic       battery_ready;
        logic [7:0] temperature;
        logic [7:0] level;
        action_t    action;
    } in_item_t;

endpackage

`default_nettype wire

// File: rtl/light_level_derating.sv
// Light level derating: thermal step-down/step-up and low-battery cut of a drive level.
// One word is accepted per clock cycle while results are taken, and each word gives exactly one
// result word: the word is held in the input register and the update logic writes the result
// register as the word leaves the input register. The level state is updated as the word
// leaves the input register, so back-to-back words see each other's effect. Both
// sides may stall freely; the input side keeps accepting while a result waits as long
// as the input register is empty. Configuration registers max_temperature (index 0,
// reset 195) and low_battery_level (index 1, reset 130) are written through the cfg
// port, which is always ready; other indexes are ignored.
`default_nettype none

`include "light_level_derating_defines.svh"

module light_level_derating #(
    parameter int MAX_LEVEL = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // config write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // level[7:0], temperature[15:8], battery_raw[23:16]
    input  wire logic [1:0]  s_axis_tuser,  // action[0], battery_ready[1]
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // drive_level[7:0]
    output logic             m_axis_tuser   // shut_down[0]
);
    import lld_pkg::*;

    localparam logic [7:0] MAX_LVL   = 8'(MAX_LEVEL);
    localparam logic [7:0] FLOOR_LVL = 8'(MAX_LEVEL / 8);
    localparam logic [7:0] HALF_LVL  = 8'(MAX_LEVEL / 2);

    logic [7:0] max_temperature_reg;
    logic [7:0] low_battery_level_reg;

    logic       in_valid_reg;
    in_item_t   in_item_reg;

    logic [7:0] target_level_reg, target_level_next;
    logic [7:0] current_level_reg, current_level_next;
    logic [7:0] heat_count_reg, heat_count_next;
    logic [3:0] low_count_reg, low_count_next;
    logic       halted_reg, halted_next;

    logic       out_valid_reg;
    logic [7:0] out_drive_reg;
    logic       out_shut_reg;

    logic       advance;
    logic       s_accept;
    logic [7:0] volts;
    logic [7:0] heat_inc;
    logic [3:0] low_inc;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_drive_reg;
    assign m_axis_tuser  = out_shut_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_temperature_reg   <= MAX_TEMPERATURE_RST;
            low_battery_level_reg <= LOW_BATTERY_LEVEL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MAX_TEMPERATURE:   max_temperature_reg   <= cfg_data;
                REG_LOW_BATTERY_LEVEL: low_battery_level_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg.action        <= action_t'(s_axis_tuser[0]);
            in_item_reg.battery_ready <= s_axis_tuser[1];
            in_item_reg.level         <= s_axis_tdata[7:0];
            in_item_reg.temperature   <= s_axis_tdata[15:8];
            in_item_reg.battery_raw   <= s_axis_tdata[23:16];
        end
    end

    assign volts    = ~in_item_reg.battery_raw;
    assign heat_inc = 8'(heat_count_reg + 8'd1);

    // level update for one word
    always_comb
    begin
        target_level_next  = target_level_reg;
        current_level_next = current_level_reg;
        heat_count_next    = heat_count_reg;
        low_count_next     = low_count_reg;
        halted_next        = halted_reg;
        low_inc            = 4'd0;

        if (in_item_reg.action == ACT_START)
        begin
            target_level_next  = in_item_reg.level;
            current_level_next = in_item_reg.level;
            heat_count_next    = 8'd0;
            low_count_next     = 4'd0;
            halted_next        = 1'b0;
        end
        else if (!halted_reg)
        begin
            // thermal regulation only for solid levels
            if (target_level_reg <= MAX_LVL)
            begin
                if (in_item_reg.temperature >= max_temperature_reg)
                begin
                    heat_count_next = heat_inc;
                    if (heat_inc > HEAT_DEBOUNCE && current_level_reg > FLOOR_LVL)
                    begin
                        current_level_next = current_level_reg - 8'd1;
                        heat_count_next    = 8'd0;
                    end
                end
                else
                begin
                    heat_count_next = 8'd0;
                    if (max_temperature_reg >= STEP_UP_GAP &&
                        in_item_reg.temperature < max_temperature_reg - STEP_UP_GAP &&
                        current_level_reg < target_level_reg)
                    begin
                        current_level_next = current_level_reg + 8'd1;
                    end
                end
            end

            if (in_item_reg.battery_ready)
            begin
                low_inc = (volts < low_battery_level_reg) ? 4'(low_count_reg + 4'd1) : 4'd0;
                low_count_next = low_inc;
                if (low_inc >= LOW_READINGS)
                begin
                    priority if (current_level_next > MAX_LVL)
                    begin
                        current_level_next = HALF_LVL;
                    end
                    else if (current_level_next > 8'd1)
                    begin
                        current_level_next = (current_level_next >> 2)
                                           + (current_level_next >> 1);
                    end
                    else
                    begin
                        halted_next = 1'b1;
                    end
                    target_level_next = current_level_next;
                    low_count_next    = 4'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_level_reg  <= 8'd0;
            current_level_reg <= 8'd0;
            heat_count_reg    <= 8'd0;
            low_count_reg     <= 4'd0;
            halted_reg        <= 1'b0;
        end
        else if (advance)
        begin
            target_level_reg  <= target_level_next;
            current_level_reg <= current_level_next;
            heat_count_reg    <= heat_count_next;
            low_count_reg     <= low_count_next;
            halted_reg        <= halted_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_drive_reg <= halted_next ? 8'd0 : current_level_next;
            out_shut_reg  <= halted_next;
        end
    end

    `LLD_ASSERT_NOW(a_shut_reports_zero, out_valid_reg && out_shut_reg,
        out_drive_reg == 8'd0, "shut down result with nonzero drive level")
    `LLD_ASSERT_NOW(a_low_count_bound, 1'b1,
        low_count_reg < LOW_READINGS, "low battery count left at cut threshold")
    `LLD_ASSERT_NOW(a_level_under_target, !halted_reg,
        current_level_reg <= target_level_reg, "drive level above target")
    `LLD_ASSERT_NEXT(a_halt_holds_on_tick, halted_reg && advance &&
        in_item_reg.action == ACT_TICK, halted_reg && out_shut_reg,
        "tick released a shut down light")

endmodule

`default_nettype wire

// File: verif/derating_checker.sv
// checker for the light level derating block: tracks the level state and compares every result
`timescale 1ns / 1ps

module derating_checker
    import lld_pkg::*;
#(
    parameter int DERATE_MAX = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // level[7:0], temperature[15:8], battery_raw[23:16]
    input  logic [1:0]  s_axis_tuser,  // action[0], battery_ready[1]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,  // drive_level[7:0]
    input  logic        m_axis_tuser,  // shut_down[0]
    output int          fail_count,
    output int          pending
);

    localparam logic [7:0] LEVEL_CAP   = 8'(DERATE_MAX);
    localparam logic [7:0] LEVEL_FLOOR = 8'(DERATE_MAX / 8);
    localparam logic [7:0] LEVEL_HALF  = 8'(DERATE_MAX / 2);

    typedef struct packed
    {
        logic [7:0] drive_level;
        logic       shut_down;
    } level_result_t;

    level_result_t expected_levels[$];

    logic [7:0] temp_limit;
    logic [7:0] batt_limit;
    logic [7:0] target_lvl;
    logic [7:0] drive_lvl;
    logic [7:0] heat_ticks;
    logic [3:0] low_ticks;
    logic       halted;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic derate_step(input in_item_t w, output level_result_t r);
        logic [7:0] volts;
        volts = 8'hFF - w.battery_raw;
        if (w.action == ACT_START)
        begin
            target_lvl = w.level;
            drive_lvl  = w.level;
            heat_ticks = '0;
            low_ticks  = '0;
            halted     = 1'b0;
        end
        else if (!halted)
        begin
            // blinky targets skip thermal regulation entirely
            if (target_lvl <= LEVEL_CAP)
            begin
                if (w.temperature >= temp_limit)
                begin
                    heat_ticks = heat_ticks + 8'd1;
                    if (heat_ticks > HEAT_DEBOUNCE && drive_lvl > LEVEL_FLOOR)
                    begin
                        drive_lvl  = drive_lvl - 8'd1;
                        heat_ticks = '0;
                    end
                end
                else
                begin
                    heat_ticks = '0;
                    if (temp_limit >= STEP_UP_GAP && w.temperature < temp_limit - STEP_UP_GAP
                        && drive_lvl < target_lvl)
                        drive_lvl = drive_lvl + 8'd1;
                end
            end
            if (w.battery_ready)
            begin
                if (volts < batt_limit)
                    low_ticks = low_ticks + 4'd1;
                else
                    low_ticks = '0;
                if (low_ticks >= LOW_READINGS)
                begin
                    if (drive_lvl > LEVEL_CAP)
                        drive_lvl = LEVEL_HALF;
                    else if (drive_lvl > 8'd1)
                        drive_lvl = (drive_lvl >> 2) + (drive_lvl >> 1);
                    else
                        halted = 1'b1;
                    target_lvl = drive_lvl;
                    low_ticks  = '0;
                end
            end
        end
        r.drive_level = halted ? 8'd0 : drive_lvl;
        r.shut_down   = halted;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        level_result_t predicted;
        in_item_t      word_in;
        if (!rst_n)
        begin
            temp_limit = MAX_TEMPERATURE_RST;
            batt_limit = LOW_BATTERY_LEVEL_RST;
            target_lvl = '0;
            drive_lvl  = '0;
            heat_ticks = '0;
            low_ticks  = '0;
            halted     = 1'b0;
            expected_levels.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MAX_TEMPERATURE)
                    temp_limit = cfg_data;
                else if (cfg_index == REG_LOW_BATTERY_LEVEL)
                    batt_limit = cfg_data;
            end
            // results leave before the word taken at this edge can have one
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_levels.size() == 0)
                begin
                    fail_count++;
                    $error("result word with nothing expected: drive_level %0d shut_down %0d",
                           m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    predicted = expected_levels.pop_front();
                    if (m_axis_tdata !== predicted.drive_level)
                    begin
                        fail_count++;
                        $error("drive_level: expected %0d, actual %0d",
                               predicted.drive_level, m_axis_tdata);
                    end
                    if (m_axis_tuser !== predicted.shut_down)
                    begin
                        fail_count++;
                        $error("shut_down: expected %0d, actual %0d",
                               predicted.shut_down, m_axis_tuser);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                word_in.action        = action_t'(s_axis_tuser[0]);
                word_in.battery_ready = s_axis_tuser[1];
                word_in.level         = s_axis_tdata[7:0];
                word_in.temperature   = s_axis_tdata[15:8];
                word_in.battery_raw   = s_axis_tdata[23:16];
                derate_step(word_in, predicted);
                expected_levels.push_back(predicted);
            end
            pending = expected_levels.size();
        end
    end

endmodule

// File: verif/testbench.sv
// top of the light level derating testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;

    import lld_pkg::*;

    localparam int         LEVEL_CAP      = 64;
    localparam logic [7:0] UNMAPPED_INDEX = 8'hFF;
    localparam int         WORDS_PER_SET  = 46;
    localparam int         SETTING_COUNT  = 7;
    localparam int         LONG_HOLD      = 300;

    typedef enum int
    {
        RX_OPEN,
        RX_MOSTLY_OPEN,
        RX_MOSTLY_SHUT,
        RX_TOGGLE
    } rx_mode_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // level[7:0], temperature[15:8], battery_raw[23:16]
    logic [1:0]  s_axis_tuser;   // action[0], battery_ready[1]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // drive_level[7:0]
    logic        m_axis_tuser;   // shut_down[0]
    int          fail_count;
    int          pending;

    logic [7:0]  hot_limit;
    logic [7:0]  low_limit;
    int          words_sent;
    int          burst_left;
    bit          offering;
    bit          hold_req;

    light_level_derating #(.MAX_LEVEL(LEVEL_CAP)) uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    derating_checker #(.DERATE_MAX(LEVEL_CAP)) monitor (.*);

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic in_item_t start_word(input logic [7:0] lvl);
        in_item_t w;
        w.action        = ACT_START;
        w.level         = lvl;
        w.temperature   = 8'($urandom);
        w.battery_ready = 1'($urandom);
        w.battery_raw   = 8'($urandom);
        return w;
    endfunction

    function automatic in_item_t tick_word(input logic [7:0] temp, input logic ready,
                                           input logic [7:0] raw);
        in_item_t w;
        w.action        = ACT_TICK;
        w.level         = 8'($urandom);
        w.temperature   = temp;
        w.battery_ready = ready;
        w.battery_raw   = raw;
        return w;
    endfunction

    function automatic logic [7:0] hot_temp();
        return 8'($urandom_range(255, hot_limit));
    endfunction

    // with a zero limit every sample counts as hot
    function automatic logic [7:0] cool_temp();
        if (hot_limit == 0)
            return 8'($urandom);
        return 8'($urandom_range(hot_limit - 1, 0));
    endfunction

    // converter byte whose inverse falls below the low battery limit
    function automatic logic [7:0] low_raw();
        if (low_limit == 0)
            return 8'($urandom);
        return 8'($urandom_range(255, 256 - low_limit));
    endfunction

    function automatic logic [7:0] good_raw();
        return 8'($urandom_range(255 - low_limit, 0));
    endfunction

    function automatic logic [7:0] setting_temp(input int p);
        case (p)
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd1;
            3: return 8'd2;
            4: return 8'd195;
            5: return 8'($urandom);
            default: return 8'd3;
        endcase
    endfunction

    function automatic logic [7:0] setting_batt(input int p);
        case (p)
            0: return 8'd255;
            1: return 8'd0;
            2: return 8'd1;
            3: return 8'd128;
            4: return 8'd130;
            5: return 8'($urandom);
            default: return 8'd254;
        endcase
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
        if (idx == REG_MAX_TEMPERATURE)
            hot_limit = val;
        else if (idx == REG_LOW_BATTERY_LEVEL)
            low_limit = val;
    endtask

    task automatic push_word(input in_item_t w);
        s_axis_tdata  <= {w.battery_raw, w.temperature, w.level};
        s_axis_tuser  <= {w.battery_ready, w.action};
        s_axis_tvalid <= 1'b1;
        offering = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(40, 1);
            if ($urandom_range(4, 0) != 0)
            begin
                s_axis_tvalid <= 1'b0;
                offering = 1'b0;
                repeat ($urandom_range(8, 1))
                    @(negedge clk);
            end
        end
    endtask

    task automatic drain();
        if (offering)
        begin
            s_axis_tvalid <= 1'b0;
            offering = 1'b0;
        end
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // start near or at a solid level, then runs of hot and cool samples
    task automatic thermal_run();
        int         pick;
        int         runs;
        int         len;
        bit         heat;
        logic [7:0] lvl;
        pick = $urandom_range(5, 0);
        if (pick == 0)
            lvl = 8'($urandom_range(12, 7));
        else if (pick == 1)
            lvl = 8'(LEVEL_CAP);
        else if (pick == 2)
            lvl = 8'd0;
        else
            lvl = 8'($urandom_range(LEVEL_CAP, 1));
        push_word(start_word(lvl));
        runs = $urandom_range(2, 1);
        repeat (runs)
        begin
            heat = $urandom_range(2, 0) != 0;
            len  = heat ? $urandom_range(30, 14) : $urandom_range(12, 1);
            repeat (len)
                push_word(tick_word(heat ? hot_temp() : cool_temp(),
                                    $urandom_range(4, 0) == 0, good_raw()));
        end
    endtask

    // mostly low readings so that cuts and shutdowns come often
    task automatic battery_run();
        int         pick;
        int         len;
        int         r;
        logic [7:0] lvl;
        pick = $urandom_range(2, 0);
        if (pick == 0)
            lvl = 8'($urandom_range(255, LEVEL_CAP + 1));
        else if (pick == 1)
            lvl = 8'($urandom_range(4, 0));
        else
            lvl = 8'($urandom);
        push_word(start_word(lvl));
        len = $urandom_range(40, 12);
        repeat (len)
        begin
            r = $urandom_range(9, 0);
            if (r == 0)
                push_word(tick_word(8'($urandom), 1'b0, 8'($urandom)));
            else if (r == 1)
                push_word(tick_word(8'($urandom), 1'b1, good_raw()));
            else
                push_word(tick_word(8'($urandom), 1'b1, low_raw()));
        end
    endtask

    task automatic noise_words();
        in_item_t w;
        repeat ($urandom_range(4, 1))
        begin
            w = tick_word(8'($urandom), 1'($urandom), 8'($urandom));
            if ($urandom_range(3, 0) == 0)
                w.action = ACT_START;
            push_word(w);
        end
    endtask

    // receiver: segments of different stall patterns, plus one long hold on request
    initial
    begin
        rx_mode_t mode;
        int       seg;
        bit       held;
        held = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            mode = rx_mode_t'($urandom_range(3, 0));
            seg  = $urandom_range(80, 10);
            repeat (seg)
            begin
                @(negedge clk);
                case (mode)
                    RX_OPEN:        m_axis_tready <= 1'b1;
                    RX_MOSTLY_OPEN: m_axis_tready <= ($urandom_range(3, 0) != 0);
                    RX_MOSTLY_SHUT: m_axis_tready <= ($urandom_range(3, 0) == 0);
                    default:        m_axis_tready <= ~m_axis_tready;
                endcase
            end
            if (hold_req && !held)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD)
                    @(negedge clk);
                held = 1'b1;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int set_start;
        int r;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        rst_n         = 1'b0;
        hold_req      = 1'b0;
        offering      = 1'b0;
        burst_left    = 0;
        words_sent    = 0;
        hot_limit     = MAX_TEMPERATURE_RST;
        low_limit     = LOW_BATTERY_LEVEL_RST;
        repeat (6)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ticks before any start: levels are zero, eight low readings shut down
        repeat (8)
            push_word(tick_word(8'd0, 1'b1, 8'd255));
        // ticks while shut down change nothing
        push_word(tick_word(8'd255, 1'b1, 8'd0));
        push_word(start_word(8'd0));
        push_word(start_word(8'd255));
        // blinky target ignores heat
        push_word(tick_word(8'd255, 1'b0, 8'd255));
        push_word(tick_word(8'd195, 1'b1, 8'd125));
        push_word(start_word(8'(LEVEL_CAP + 1)));
        push_word(tick_word(8'd255, 1'b1, 8'd126));
        push_word(start_word(8'(LEVEL_CAP)));
        push_word(tick_word(8'd194, 1'b0, 8'd0));
        push_word(tick_word(8'd192, 1'b1, 8'd0));
        push_word(start_word(8'd1));
        push_word(tick_word(8'd0, 1'b1, 8'd0));
        push_word(tick_word(8'd195, 1'b0, 8'd255));
        drain();

        // writes to an index outside the register map are dropped
        write_reg(UNMAPPED_INDEX, 8'hA5);
        write_reg(8'($urandom_range(254, 2)), 8'h5A);

        for (int p = 0; p < SETTING_COUNT; p++)
        begin
            write_reg(REG_MAX_TEMPERATURE, setting_temp(p));
            write_reg(REG_LOW_BATTERY_LEVEL, setting_batt(p));
            if (p == 1)
                hold_req = 1'b1;
            set_start = words_sent;
            while (words_sent - set_start < WORDS_PER_SET)
            begin
                r = $urandom_range(9, 0);
                if (r < 4)
                    thermal_run();
                else if (r < 8)
                    battery_run();
                else
                    noise_words();
            end
            drain();
        end

        repeat (10)
            @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: light_level_derating.f
+incdir+rtl
rtl/lld_pkg.sv
rtl/light_level_derating.sv
verif/derating_checker.sv
verif/testbench.sv
